/* rtl/lsfx_pkg.sv */
// ----------------------------------------------------------------------------
// lsfx_pkg: shared types, codes and helpers for the LED strip effect generator
// Command, mode and register codes, controller/datapath structs, the level
// scaler and the three-segment color wheel.
// ----------------------------------------------------------------------------
package lsfx_pkg;

  localparam int PIXEL_COUNT_DEF = 60;

  localparam int CMD_W   = 2;
  localparam int TIME_W  = 32;
  localparam int IDX_W   = 6;
  localparam int COLOR_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PHASE_W = 11;

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECOLOR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OFF     = 2'd2;

  localparam logic [2:0] MODE_SCANNER = 3'd1;
  localparam logic [2:0] MODE_RAINBOW = 3'd2;
  localparam logic [2:0] MODE_FULL    = 3'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_IVL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAINBOW_IVL = 3'd5;

  localparam logic [15:0] SCAN_IVL_RST    = 16'd50;
  localparam logic [15:0] RAINBOW_IVL_RST = 16'd20;
  localparam logic [PHASE_W-1:0] PHASE_WRAP = 11'd1280;
  localparam logic [COLOR_W-1:0] SCAN_DEFAULT_COLOR = 24'h00FF00;
  localparam logic [COLOR_W-1:0] BLACK = 24'h000000;
  localparam int BLANK_LAG = 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } lsfx_state_t;

  typedef enum logic [1:0] {
    EMIT_FILL,
    EMIT_RAINBOW,
    EMIT_SCAN
  } emit_kind_t;

  typedef struct packed {
    logic capture;
    logic evaluate;
    logic emit;
  } lsfx_cmd_t;

  typedef struct packed {
    logic has_writes;
    logic out_free;
    logic final_write;
  } lsfx_status_t;

  // floor(level*255/100), saturated; /100 done as *5243 >> 19 (exact for 15-bit x)
  function automatic logic [7:0] scale_level(input logic [6:0] lvl);
    logic [14:0] x;
    logic [27:0] p;
    logic [8:0]  q;
    x = {lvl, 8'b0} - {8'b0, lvl};
    p = {13'b0, x} * 28'd5243;
    q = p[27:19];
    return (q > 9'd255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [COLOR_W-1:0] wheel(input logic [7:0] w);
    logic [7:0] v;
    logic [9:0] t;
    logic [7:0] up;
    logic [7:0] dn;
    if (w < 8'd85) begin
      v = w;
    end else if (w < 8'd170) begin
      v = w - 8'd85;
    end else begin
      v = w - 8'd170;
    end
    t  = {2'b0, v} + {1'b0, v, 1'b0};
    up = t[7:0];
    dn = 8'd255 - t[7:0];
    if (w < 8'd85) begin
      return {up, dn, 8'd0};
    end else if (w < 8'd170) begin
      return {dn, 8'd0, up};
    end else begin
      return {8'd0, up, dn};
    end
  endfunction

endpackage

/* rtl/lsfx_cmd_if.sv */
// ----------------------------------------------------------------------------
// lsfx_cmd_if: command channel
// One beat carries a command code and the millisecond time.
// ----------------------------------------------------------------------------
interface lsfx_cmd_if
  import lsfx_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, command, now_ms, input ready);
  modport sink   (input valid, command, now_ms, output ready);
endinterface

/* rtl/lsfx_pix_if.sv */
// ----------------------------------------------------------------------------
// lsfx_pix_if: pixel write channel
// One beat is one pixel write; last_write flags the final write of a command.
// ----------------------------------------------------------------------------
interface lsfx_pix_if
  import lsfx_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   pixel_index;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_write;

  modport source (output valid, pixel_index, pixel_color, last_write, input ready);
  modport sink   (input valid, pixel_index, pixel_color, last_write, output ready);
endinterface

/* rtl/led_strip_effect_generator.sv */
// ----------------------------------------------------------------------------
// led_strip_effect_generator: LED strip effect engine
// Turns tick, recolor and off commands into a stream of pixel writes.
// ----------------------------------------------------------------------------
// A command beat is taken when the block is idle; it is evaluated in the next
// cycle and then its pixel writes leave one per cycle, while the pixel channel
// does not stall, through a single output register, the last one flagged by
// last_write. Off, a full-color paint and a rainbow step write all PIXEL_COUNT
// pixels; a scanner step writes one or two pixels, none when the position
// wraps; a command with no writes returns to idle after evaluation. A stalled
// pixel channel holds the writes back. Configuration must be written only
// between commands; the block itself does not enforce this. Levels are scaled
// to bytes when written and colors are packed green, red, blue from bit 23.
module led_strip_effect_generator
  import lsfx_pkg::*;
#(
  parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lsfx_cmd_if.sink              cmd,
  lsfx_pix_if.source            pix
);

  lsfx_cmd_t    ctl;
  lsfx_status_t status;
  logic         ready;

  assign cmd.ready = ready;

  lsfx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (ready),
    .status    (status),
    .ctl       (ctl)
  );

  lsfx_dp #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .command     (cmd.command),
    .now_ms      (cmd.now_ms),
    .ctl         (ctl),
    .status      (status),
    .out_ready   (pix.ready),
    .out_valid   (pix.valid),
    .pixel_index (pix.pixel_index),
    .pixel_color (pix.pixel_color),
    .last_write  (pix.last_write)
  );

endmodule

/* rtl/lsfx_ctrl.sv */
// ----------------------------------------------------------------------------
// lsfx_ctrl: command sequencer
// Takes a command, has the datapath evaluate it, then steps out pixel writes.
// ----------------------------------------------------------------------------
module lsfx_ctrl
  import lsfx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  lsfx_status_t status,
  output lsfx_cmd_t    ctl
);

  lsfx_state_t state;
  lsfx_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd_ready    = 1'b0;
    ctl          = '0;
    case (state)
      ST_IDLE: begin
        cmd_ready   = 1'b1;
        ctl.capture = cmd_valid;
        if (cmd_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        ctl.evaluate = 1'b1;
        state_next   = status.has_writes ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        ctl.emit = status.out_free;
        if (status.out_free && status.final_write) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/lsfx_dp.sv */
// ----------------------------------------------------------------------------
// lsfx_dp: effect datapath
// Configuration registers, effect state, pixel write sequencing and the
// output register.
// ----------------------------------------------------------------------------
module lsfx_dp
  import lsfx_pkg::*;
#(
  parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]      command,
  input  logic [TIME_W-1:0]     now_ms,
  input  lsfx_cmd_t             ctl,
  output lsfx_status_t          status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [IDX_W-1:0]      pixel_index,
  output logic [COLOR_W-1:0]    pixel_color,
  output logic                  last_write
);

  localparam int PW = $clog2(PIXEL_COUNT + 1);
  localparam int HUE_STEP = 256 / PIXEL_COUNT;
  localparam int HUE_REM  = 256 % PIXEL_COUNT;
  localparam logic [PW-1:0]    NPIX     = PW'(PIXEL_COUNT);
  localparam logic [PW-1:0]    LAG      = PW'(BLANK_LAG);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);
  localparam logic [7:0]       STEP8    = 8'(HUE_STEP);
  localparam logic [6:0]       REM7     = 7'(HUE_REM);
  localparam logic [6:0]       NPIX7    = 7'(PIXEL_COUNT);

  // configuration
  logic [2:0]  mode;
  logic [7:0]  red_byte;
  logic [7:0]  green_byte;
  logic [7:0]  blue_byte;
  logic [15:0] scan_ivl;
  logic [15:0] rainbow_ivl;

  // effect state
  logic [TIME_W-1:0]  last_time;
  logic [PW-1:0]      scan_pos;
  logic [PHASE_W-1:0] phase;
  logic               painted;

  // captured command
  logic [CMD_W-1:0]  cap_cmd;
  logic [TIME_W-1:0] cap_now;

  // write sequencing
  emit_kind_t         kind;
  logic [COLOR_W-1:0] fill_color;
  logic [IDX_W-1:0]   idx_a;
  logic [IDX_W-1:0]   idx_b;
  logic [7:0]         hue;
  logic [7:0]         hue_q;
  logic [6:0]         hue_r;
  logic [IDX_W-1:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= '0;
      red_byte    <= '0;
      green_byte  <= '0;
      blue_byte   <= '0;
      scan_ivl    <= SCAN_IVL_RST;
      rainbow_ivl <= RAINBOW_IVL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EFFECT_MODE: mode        <= cfg_data[2:0];
        CFG_RED_LEVEL:   red_byte    <= scale_level(cfg_data[6:0]);
        CFG_GREEN_LEVEL: green_byte  <= scale_level(cfg_data[6:0]);
        CFG_BLUE_LEVEL:  blue_byte   <= scale_level(cfg_data[6:0]);
        CFG_SCAN_IVL:    scan_ivl    <= cfg_data;
        CFG_RAINBOW_IVL: rainbow_ivl <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cap_cmd <= command;
      cap_now <= now_ms;
    end
  end

  // evaluation of the captured command
  logic [TIME_W-1:0]  elapsed;
  logic               is_tick;
  logic               scan_go;
  logic               scan_wrap;
  logic               rainbow_go;
  logic               full_go;
  logic [PW-1:0]      pos_inc;
  logic               pos_lit;
  logic [PW-1:0]      off_pos;
  logic [PHASE_W-1:0] phase_inc;
  logic [COLOR_W-1:0] level_color;
  logic               levels_zero;
  logic               writes_due;

  always_comb begin
    elapsed     = cap_now - last_time;
    is_tick     = (cap_cmd == CMD_TICK);
    scan_go     = is_tick && (mode == MODE_SCANNER) && (elapsed >= {16'b0, scan_ivl});
    rainbow_go  = is_tick && (mode == MODE_RAINBOW) && (elapsed >= {16'b0, rainbow_ivl});
    full_go     = is_tick && (mode == MODE_FULL) && !painted;
    scan_wrap   = scan_pos >= NPIX;
    pos_inc     = scan_pos + PW'(1);
    pos_lit     = pos_inc < NPIX;
    off_pos     = (pos_inc >= LAG) ? (pos_inc - LAG) : (pos_inc + NPIX - LAG);
    phase_inc   = phase + PHASE_W'(1);
    level_color = {green_byte, red_byte, blue_byte};
    levels_zero = (level_color == BLACK);
    writes_due  = (cap_cmd == CMD_OFF) || (scan_go && !scan_wrap) ||
                  rainbow_go || full_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
      scan_pos  <= '0;
      phase     <= '0;
      painted   <= 1'b0;
    end else if (ctl.evaluate) begin
      if (cap_cmd == CMD_RECOLOR || cap_cmd == CMD_OFF) begin
        painted <= 1'b0;
      end
      if (full_go) begin
        painted <= 1'b1;
      end
      if (scan_go || rainbow_go) begin
        last_time <= cap_now;
      end
      if (scan_go) begin
        scan_pos <= scan_wrap ? '0 : pos_inc;
      end
      if (rainbow_go) begin
        phase <= (phase_inc == PHASE_WRAP) ? '0 : phase_inc;
      end
    end
  end

  // per-pixel sequencing; hue offset i*256/N kept as quotient and remainder
  logic [6:0] r_sum;
  assign r_sum = hue_r + REM7;

  always_ff @(posedge clk) begin
    if (ctl.evaluate) begin
      hue_q <= '0;
      hue_r <= '0;
      hue   <= phase_inc[7:0];
      idx_a <= IDX_W'(pos_inc);
      idx_b <= IDX_W'(off_pos);
      if (cap_cmd == CMD_OFF) begin
        kind       <= EMIT_FILL;
        fill_color <= BLACK;
        cnt        <= '0;
      end else if (rainbow_go) begin
        kind <= EMIT_RAINBOW;
        cnt  <= '0;
      end else if (scan_go) begin
        kind       <= EMIT_SCAN;
        fill_color <= levels_zero ? SCAN_DEFAULT_COLOR : level_color;
        cnt        <= pos_lit ? IDX_W'(0) : IDX_W'(1);
      end else begin
        kind       <= EMIT_FILL;
        fill_color <= level_color;
        cnt        <= '0;
      end
    end else if (ctl.emit) begin
      cnt <= cnt + IDX_W'(1);
      if (r_sum >= NPIX7) begin
        hue_r <= r_sum - NPIX7;
        hue_q <= hue_q + STEP8 + 8'd1;
      end else begin
        hue_r <= r_sum;
        hue_q <= hue_q + STEP8;
      end
    end
  end

  logic [IDX_W-1:0]   cur_idx;
  logic [COLOR_W-1:0] cur_color;

  always_comb begin
    status.has_writes = writes_due;
    status.out_free   = !out_valid || out_ready;
    case (kind)
      EMIT_SCAN: begin
        status.final_write = (cnt == IDX_W'(1));
        cur_idx   = (cnt == '0) ? idx_a : idx_b;
        cur_color = (cnt == '0) ? fill_color : BLACK;
      end
      EMIT_RAINBOW: begin
        status.final_write = (cnt == LAST_IDX);
        cur_idx   = cnt;
        cur_color = wheel(hue_q + hue);
      end
      default: begin
        status.final_write = (cnt == LAST_IDX);
        cur_idx   = cnt;
        cur_color = fill_color;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pixel_index <= cur_idx;
      pixel_color <= cur_color;
      last_write  <= status.final_write;
    end
  end

endmodule

/* sim/led_strip_effect_generator_tb.sv */
// ----------------------------------------------------------------------------
// led_strip_effect_generator_tb: self-checking bench for the LED strip effects
// Command beats from a pending queue go to the block; a behavioral strip model
// predicts every pixel write and a monitor checks each output beat in order.
// Directed corner cases come first. Random phases with random register
// settings and random stalls on both sides follow, then a short stall-free
// rainbow run.
// ----------------------------------------------------------------------------
module led_strip_effect_generator_tb
  import lsfx_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PIX        = PIXEL_COUNT_DEF;
  localparam int CYCLE_LIMIT  = 2_500_000;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 400;
  localparam int FINAL_TICKS  = 30;
  localparam int MAX_REPORTS  = 40;

  localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_DISCO    = 3'd4;
  localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
  localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] now_ms;
  } cmd_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_write;
  } pix_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic              src_valid = 1'b0;
  logic [CMD_W-1:0]  src_cmd   = '0;
  logic [TIME_W-1:0] src_now   = '0;
  logic              snk_ready = 1'b0;

  lsfx_cmd_if cmd_ch ();
  lsfx_pix_if pix_ch ();

  assign cmd_ch.valid   = src_valid;
  assign cmd_ch.command = src_cmd;
  assign cmd_ch.now_ms  = src_now;
  assign pix_ch.ready   = snk_ready;

  led_strip_effect_generator #(
    .PIXEL_COUNT(N_PIX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd_ch),
    .pix      (pix_ch)
  );

  always #1 clk = ~clk;

  // strip model: register copies and effect state
  logic [2:0]  reg_mode     = MODE_NONE;
  logic [6:0]  reg_red      = '0;
  logic [6:0]  reg_green    = '0;
  logic [6:0]  reg_blue     = '0;
  logic [15:0] reg_scan_ivl = SCAN_IVL_RST;
  logic [15:0] reg_rb_ivl   = RAINBOW_IVL_RST;

  logic [31:0]        fx_last_ms  = '0;
  logic [6:0]         fx_scan_pos = '0;
  logic [PHASE_W-1:0] fx_phase    = '0;
  logic               fx_painted  = 1'b0;

  cmd_beat_t  cmd_pend_q[$];
  pix_write_t pix_writes_due[$];

  int idle_rate     = 0;
  bit long_hold_arm = 1'b0;
  int src_gap       = 0;
  int snk_gap       = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  int unsigned cycle_cnt   = 0;
  int          err_cnt     = 0;
  int          beats_taken = 0;
  int          writes_seen = 0;
  int          rb_wraps    = 0;
  int          phase_cnt   = 0;
  logic [31:0] t_ms        = '0;

  function automatic logic [7:0] pct_to_byte(input logic [6:0] pct);
    int unsigned v;
    v = int'(pct) * 255 / 100;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [COLOR_W-1:0] level_color();
    return {pct_to_byte(reg_green), pct_to_byte(reg_red), pct_to_byte(reg_blue)};
  endfunction

  function automatic logic [COLOR_W-1:0] wheel_color(input logic [7:0] w);
    int unsigned s;
    if (w < 8'd85) begin
      s = 3 * int'(w);
      return {8'(s), 8'(255 - s), 8'h00};
    end else if (w < 8'd170) begin
      s = 3 * (int'(w) - 85);
      return {8'(255 - s), 8'h00, 8'(s)};
    end else begin
      s = 3 * (int'(w) - 170);
      return {8'h00, 8'(s), 8'(255 - s)};
    end
  endfunction

  function automatic logic [6:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [15:0] pick_ivl();
    case ($urandom_range(0, 7))
      0, 1:    return 16'd0;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 60));
    endcase
  endfunction

  task automatic push_write(input int idx, input logic [COLOR_W-1:0] color);
    pix_write_t w;
    w.pixel_index = IDX_W'(idx);
    w.pixel_color = color;
    w.last_write  = 1'b0;
    pix_writes_due.push_back(w);
  endtask

  // advance the strip model by one accepted command beat
  task automatic predict_writes(input cmd_beat_t b);
    logic [31:0]        elapsed;
    logic [COLOR_W-1:0] lit;
    int                 n0;
    int                 i;
    n0 = pix_writes_due.size();
    elapsed = b.now_ms - fx_last_ms;
    case (b.command)
      CMD_RECOLOR: fx_painted = 1'b0;
      CMD_OFF: begin
        fx_painted = 1'b0;
        for (i = 0; i < N_PIX; i++) push_write(i, BLACK);
      end
      CMD_TICK: begin
        if (reg_mode == MODE_SCANNER) begin
          if (elapsed >= {16'b0, reg_scan_ivl}) begin
            fx_last_ms = b.now_ms;
            if (fx_scan_pos < N_PIX) begin
              if (reg_red == 0 && reg_green == 0 && reg_blue == 0) begin
                lit = SCAN_DEFAULT_COLOR;
              end else begin
                lit = level_color();
              end
              fx_scan_pos = fx_scan_pos + 7'd1;
              // the write at the end position is dropped, the blank is not
              if (fx_scan_pos < N_PIX) push_write(int'(fx_scan_pos), lit);
              if (fx_scan_pos >= BLANK_LAG) begin
                push_write(int'(fx_scan_pos) - BLANK_LAG, BLACK);
              end else begin
                push_write(int'(fx_scan_pos) + N_PIX - BLANK_LAG, BLACK);
              end
            end else begin
              fx_scan_pos = '0;
            end
          end
        end else if (reg_mode == MODE_RAINBOW) begin
          if (elapsed >= {16'b0, reg_rb_ivl}) begin
            fx_last_ms = b.now_ms;
            fx_phase = fx_phase + 1'b1;
            for (i = 0; i < N_PIX; i++) begin
              push_write(i, wheel_color(8'((i * 256 / N_PIX) + int'(fx_phase))));
            end
            if (fx_phase == PHASE_WRAP) begin
              fx_phase = '0;
              rb_wraps++;
            end
          end
        end else if (reg_mode == MODE_FULL) begin
          if (!fx_painted) begin
            fx_painted = 1'b1;
            lit = level_color();
            for (i = 0; i < N_PIX; i++) push_write(i, lit);
          end
        end
      end
      default: ;
    endcase
    if (pix_writes_due.size() > n0) begin
      pix_writes_due[pix_writes_due.size() - 1].last_write = 1'b1;
    end
  endtask

  // command driver
  always @(posedge clk) begin : cmd_drive
    cmd_beat_t beat;
    if (rst) begin
      src_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (src_valid && cmd_ch.ready) begin
        beat = cmd_pend_q.pop_front();
        predict_writes(beat);
        beats_taken++;
        if ($urandom_range(0, 99) < idle_rate) src_gap = $urandom_range(1, 15);
      end else if (!src_valid && src_gap == 0 && cmd_pend_q.size() != 0 &&
                   $urandom_range(0, 99) < idle_rate) begin
        src_gap = $urandom_range(1, 15);
      end
      // an offered beat stays put until it is taken
      if (!src_valid || cmd_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          src_valid <= 1'b0;
        end else if (cmd_pend_q.size() != 0) begin
          src_valid <= 1'b1;
          src_cmd   <= cmd_pend_q[0].command;
          src_now   <= cmd_pend_q[0].now_ms;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor and receiver stalls
  always @(posedge clk) begin : pix_check
    pix_write_t w;
    if (rst) begin
      snk_ready <= 1'b0;
    end else begin
      if (pix_ch.valid && snk_ready) begin
        writes_seen++;
        if (pix_writes_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("%0t: unexpected pixel write idx %0d color %06h last %0b", $time,
                     pix_ch.pixel_index, pix_ch.pixel_color, pix_ch.last_write);
          end
        end else begin
          w = pix_writes_due.pop_front();
          if (w.pixel_index != pix_ch.pixel_index || w.pixel_color != pix_ch.pixel_color ||
              w.last_write != pix_ch.last_write) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display({"%0t: mismatch idx exp %0d got %0d, color exp %06h got %06h,",
                        " last exp %0b got %0b"},
                       $time, w.pixel_index, pix_ch.pixel_index, w.pixel_color,
                       pix_ch.pixel_color, w.last_write, pix_ch.last_write);
            end
          end
        end
      end
      if (long_hold_arm && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        snk_ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        snk_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_rate) begin
        snk_gap = $urandom_range(0, 14);
        snk_ready <= 1'b0;
      end else begin
        snk_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d writes still due", $time, cycle_cnt,
               pix_writes_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] now);
    cmd_beat_t b;
    b.command = c;
    b.now_ms  = now;
    cmd_pend_q.push_back(b);
  endtask

  // block idle: no beat pending, none offered, no write due
  task automatic settle();
    while (cmd_pend_q.size() != 0 || src_valid || pix_writes_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    case (idx)
      CFG_EFFECT_MODE: reg_mode     = data[2:0];
      CFG_RED_LEVEL:   reg_red      = data[6:0];
      CFG_GREEN_LEVEL: reg_green    = data[6:0];
      CFG_BLUE_LEVEL:  reg_blue     = data[6:0];
      CFG_SCAN_IVL:    reg_scan_ivl = data;
      CFG_RAINBOW_IVL: reg_rb_ivl   = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          random_left;
    int          r;
    int          k;
    int          n;
    logic [2:0]  mode;
    logic [1:0]  c;
    int unsigned ivl;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset settings, mode none
    idle_rate = 10;
    queue_cmd(CMD_TICK, 32'hFFFF_FFFF);
    queue_cmd(CMD_UNDEF, 32'h0);
    queue_cmd(CMD_RECOLOR, 32'h0);
    queue_cmd(CMD_OFF, 32'h0);
    settle();

    // scanner, all levels zero -> default color, interval at its reset value
    write_reg(CFG_EFFECT_MODE, {13'b0, MODE_SCANNER});
    queue_cmd(CMD_TICK, 32'd49);
    queue_cmd(CMD_TICK, 32'd50);
    queue_cmd(CMD_TICK, 32'd99);
    queue_cmd(CMD_TICK, 32'd100);
    settle();

    // saturating and extreme levels, zero interval
    write_reg(CFG_RED_LEVEL, 16'd100);
    write_reg(CFG_GREEN_LEVEL, 16'd127);
    write_reg(CFG_BLUE_LEVEL, 16'd0);
    write_reg(CFG_SCAN_IVL, 16'd0);
    queue_cmd(CMD_TICK, 32'd100);
    queue_cmd(CMD_TICK, 32'd100);
    settle();

    // full paint once, repaint after recolor and after off
    write_reg(CFG_EFFECT_MODE, {13'b0, MODE_FULL});
    queue_cmd(CMD_TICK, 32'd100);
    queue_cmd(CMD_TICK, 32'd100);
    queue_cmd(CMD_RECOLOR, 32'd100);
    queue_cmd(CMD_TICK, 32'd100);
    queue_cmd(CMD_OFF, 32'd100);
    queue_cmd(CMD_TICK, 32'd100);
    settle();

    // rainbow at the longest interval: one short of it, exactly it, time wrap
    write_reg(CFG_EFFECT_MODE, {13'b0, MODE_RAINBOW});
    write_reg(CFG_RAINBOW_IVL, 16'hFFFF);
    queue_cmd(CMD_TICK, 32'd100 + 32'd65534);
    queue_cmd(CMD_TICK, 32'd100 + 32'd65535);
    queue_cmd(CMD_TICK, 32'd5);
    settle();
    write_reg(CFG_RAINBOW_IVL, 16'd0);
    queue_cmd(CMD_TICK, 32'd5);
    settle();

    // modes that write nothing
    write_reg(CFG_EFFECT_MODE, {13'b0, MODE_DISCO});
    queue_cmd(CMD_TICK, 32'd5);
    settle();
    write_reg(CFG_EFFECT_MODE, {13'b0, MODE_UNDEF_LO});
    queue_cmd(CMD_TICK, 32'd5);
    settle();
    write_reg(CFG_EFFECT_MODE, {13'b0, MODE_UNDEF_HI});
    queue_cmd(CMD_TICK, 32'd5);
    t_ms = 32'd5;

    // random phases: mostly ticks with time advancing around the interval
    random_left = RANDOM_ITEMS;
    while (random_left > 0) begin
      settle();
      phase_cnt++;
      r = $urandom_range(0, 99);
      if (r < 35) begin
        mode = MODE_SCANNER;
      end else if (r < 65) begin
        mode = MODE_RAINBOW;
      end else if (r < 85) begin
        mode = MODE_FULL;
      end else if (r < 90) begin
        mode = MODE_NONE;
      end else if (r < 95) begin
        mode = MODE_DISCO;
      end else begin
        mode = 3'($urandom_range(5, 7));
      end
      write_reg(CFG_EFFECT_MODE, {13'b0, mode});
      if ($urandom_range(0, 6) == 0) begin
        write_reg(CFG_RED_LEVEL, 16'd0);
        write_reg(CFG_GREEN_LEVEL, 16'd0);
        write_reg(CFG_BLUE_LEVEL, 16'd0);
      end else begin
        write_reg(CFG_RED_LEVEL, {9'b0, pick_level()});
        write_reg(CFG_GREEN_LEVEL, {9'b0, pick_level()});
        write_reg(CFG_BLUE_LEVEL, {9'b0, pick_level()});
      end
      write_reg(CFG_SCAN_IVL, pick_ivl());
      write_reg(CFG_RAINBOW_IVL, pick_ivl());
      case ($urandom_range(0, 2))
        0:       idle_rate = 0;
        1:       idle_rate = 5;
        default: idle_rate = 20;
      endcase
      // long receiver hold in a phase that keeps the block busy
      if (phase_cnt >= 3 && !long_hold_arm &&
          (mode == MODE_SCANNER || mode == MODE_RAINBOW)) begin
        long_hold_arm = 1'b1;
      end
      n = (mode == MODE_SCANNER) ? $urandom_range(30, 70) : $urandom_range(10, 30);
      ivl = (mode == MODE_SCANNER) ? int'(reg_scan_ivl) : int'(reg_rb_ivl);
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          c = CMD_RECOLOR;
        end else if (r < 10) begin
          c = CMD_OFF;
        end else if (r < 13) begin
          c = CMD_UNDEF;
        end else begin
          c = CMD_TICK;
        end
        case ($urandom_range(0, 19))
          0:       t_ms = $urandom;
          1:       t_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
          default: t_ms = t_ms + 32'($urandom_range(0, ivl + ivl / 2 + 1));
        endcase
        queue_cmd(c, t_ms);
        random_left--;
      end
    end

    // short stall-free rainbow run
    settle();
    idle_rate = 0;
    write_reg(CFG_EFFECT_MODE, {13'b0, MODE_RAINBOW});
    write_reg(CFG_RAINBOW_IVL, 16'd0);
    for (k = 0; k < FINAL_TICKS; k++) begin
      t_ms = t_ms + 32'd1;
      queue_cmd(CMD_TICK, t_ms);
    end
    settle();
    repeat (50) @(negedge clk);
    if (pix_writes_due.size() != 0) err_cnt++;

    $display("Covered %0d command beats over %0d random phases, %0d pixel writes checked,",
             beats_taken, phase_cnt, writes_seen);
    $display("rainbow phase wrapped %0d time(s), %0d mismatch(es)", rb_wraps, err_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lsfx_pkg.sv
rtl/lsfx_cmd_if.sv
rtl/lsfx_pix_if.sv
rtl/lsfx_ctrl.sv
rtl/lsfx_dp.sv
rtl/led_strip_effect_generator.sv
sim/led_strip_effect_generator_tb.sv
